@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the LZ78 compressor RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LZ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lz78c assertion failed");

`define LZ_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`else

`define LZ_ASSERT(lbl, clk, rst, prop)
`define LZ_ASSERT_MSG(lbl, clk, rst, prop, msg)

`endif

`endif

@@ hw/rtl/lz78c_pkg.sv @@
// Types and fixed constants of the LZ78 compressor.
// Used by lz78c_hash, lz78c_seq and lz78_compressor; depends on nothing.
package lz78c_pkg;

   localparam int PREFIX_W   = 12;
   localparam int BYTE_W     = 8;
   localparam int LIMIT_W    = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
   localparam logic [31:0]        HASH_MULT   = 32'd2654435761;

   // register index decoded from csr_paddr[2]
   localparam logic REG_DICT_LIMIT = 1'b0;

   typedef struct packed {
      logic [PREFIX_W-1:0] prefix_code;
      logic [BYTE_W-1:0]   out_byte;
      logic                is_flush;
      logic                stream_last;
      logic                dict_full;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } hash_cmd_type;

endpackage

@@ hw/rtl/lz78c_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the hashed phrase table; depends on nothing.
module lz78c_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lz78c_hash.sv @@
// Probe address unit: multiplicative hash of a key, then linear stepping.
// Uses lz78c_pkg; the slot count is a power of two, so the wrap is free.
module lz78c_hash import lz78c_pkg::*; #(
   parameter int KEY_W  = 20,
   parameter int SLOT_W = 13
) (
   input  logic              clock,
   input  hash_cmd_type      cmd,
   input  logic [KEY_W-1:0]  key,
   output logic [SLOT_W-1:0] idx
);

   logic [SLOT_W-1:0] prod;
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] idx_in;

   assign prod = SLOT_W'(key) * HASH_MULT[SLOT_W-1:0];

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = prod;
      end else if (cmd.step) begin
         idx_in = idx_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign idx = idx_ff;

endmodule

@@ hw/rtl/lz78c_seq.sv @@
// Sequencer of the LZ78 compressor: clear pass, table probe, insert, result.
// Uses lz78c_pkg and assert_macros.svh; drives lz78c_hash and lz78c_ram.
`include "assert_macros.svh"
module lz78c_seq import lz78c_pkg::*; #(
   parameter int DICT_SIZE  = 4096,
   parameter int HASH_SLOTS = 8192,
   parameter int CODE_W     = 12,
   parameter int SLOT_W     = 13,
   parameter int KEY_W      = 20,
   parameter int ENTRY_W    = 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] dict_limit,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_in_byte,
   input  logic               req_end_of_stream,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   output hash_cmd_type       hash_cmd,
   output logic [KEY_W-1:0]   hash_key,
   input  logic [SLOT_W-1:0]  hash_idx,
   output logic               ram_wr_en,
   output logic [SLOT_W-1:0]  ram_wr_addr,
   output logic [ENTRY_W-1:0] ram_wr_data,
   output logic               ram_rd_en,
   output logic [SLOT_W-1:0]  ram_rd_addr,
   input  logic [ENTRY_W-1:0] ram_rd_data
);

   localparam int NC_W  = $clog2(DICT_SIZE + 1);
   localparam int CMP_W = (NC_W + 1 > LIMIT_W) ? NC_W + 1 : LIMIT_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_CHECK = 2'd3;

   logic [1:0]        state_ff,     state_in;
   logic [SLOT_W-1:0] clr_addr_ff,  clr_addr_in;
   logic [SLOT_W-1:0] probe_cnt_ff, probe_cnt_in;
   logic [BYTE_W-1:0] byte_ff,      byte_in;
   logic              last_ff,      last_in;
   logic [CODE_W-1:0] prefix_ff,    prefix_in;
   logic [NC_W-1:0]   next_code_ff, next_code_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff,  rsp_data_in;

   logic [CMP_W-1:0]  lim_raw;
   logic [CMP_W-1:0]  lim;
   logic [CMP_W-1:0]  ncode;
   logic              next_ge;
   logic              next1_ge;
   logic [KEY_W-1:0]  key;
   logic              ent_valid;
   logic [KEY_W-1:0]  ent_key;
   logic [CODE_W-1:0] ent_code;
   logic              hit;
   logic              probe_last;
   logic              resolve;
   logic              need_out;
   logic              out_free;
   logic              commit;
   logic              add;

   assign lim_raw = CMP_W'(dict_limit);
   always_comb begin
      lim = lim_raw;
      if (lim_raw < CMP_W'(2)) begin
         lim = CMP_W'(2);
      end else if (lim_raw > CMP_W'(DICT_SIZE)) begin
         lim = CMP_W'(DICT_SIZE);
      end
   end

   assign ncode    = CMP_W'(next_code_ff);
   assign next_ge  = ncode >= lim;
   assign next1_ge = (ncode + CMP_W'(1)) >= lim;

   assign key       = {prefix_ff, byte_ff};
   assign hash_key  = {prefix_ff, req_in_byte};
   assign ent_valid = ram_rd_data[ENTRY_W-1];
   assign ent_key   = ram_rd_data[ENTRY_W-2 -: KEY_W];
   assign ent_code  = ram_rd_data[CODE_W-1:0];

   assign hit        = ent_valid && (ent_key == key);
   assign probe_last = probe_cnt_ff == SLOT_W'(HASH_SLOTS - 1);
   assign resolve    = hit || !ent_valid || probe_last;
   assign need_out   = !hit || last_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign commit     = (state_ff == ST_CHECK) && resolve && (!need_out || out_free);
   assign add        = !hit && !ent_valid && !next_ge;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      probe_cnt_in = probe_cnt_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      prefix_in    = prefix_ff;
      next_code_in = next_code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      hash_cmd     = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = hash_idx;
      ram_wr_data  = {1'b1, key, next_code_ff[CODE_W-1:0]};
      ram_rd_en    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + SLOT_W'(1);
            if (clr_addr_ff == SLOT_W'(HASH_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               hash_cmd.load = 1'b1;
               byte_in       = req_in_byte;
               last_in       = req_end_of_stream;
               probe_cnt_in  = '0;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (!resolve) begin
               hash_cmd.step = 1'b1;
               probe_cnt_in  = probe_cnt_ff + SLOT_W'(1);
               state_in      = ST_READ;
            end else if (commit) begin
               ram_wr_en = add;
               if (add) begin
                  next_code_in = next_code_ff + NC_W'(1);
               end
               if (need_out) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.prefix_code = hit ? PREFIX_W'(ent_code) : PREFIX_W'(prefix_ff);
                  rsp_data_in.out_byte    = hit ? '0 : byte_ff;
                  rsp_data_in.is_flush    = hit;
                  rsp_data_in.stream_last = last_ff;
                  rsp_data_in.dict_full   = hit ? next_ge : (add ? next1_ge : 1'b1);
               end
               prefix_in = hit ? ent_code : '0;
               state_in  = ST_IDLE;
               if (last_ff) begin
                  prefix_in    = '0;
                  next_code_in = NC_W'(1);
                  clr_addr_in  = '0;
                  state_in     = ST_CLEAR;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         prefix_ff    <= '0;
         next_code_ff <= NC_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         prefix_ff    <= prefix_in;
         next_code_ff <= next_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      probe_cnt_ff <= probe_cnt_in;
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready   = state_ff == ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign ram_rd_addr = hash_idx;

   `LZ_ASSERT(a_accept_reads, clock, reset,
      (req_valid && req_ready) |=> (state_ff == ST_READ))
   `LZ_ASSERT(a_no_insert_on_hit, clock, reset,
      (state_ff == ST_CHECK && ram_wr_en) |-> (!hit && !ent_valid))
   `LZ_ASSERT(a_stream_end_clears, clock, reset,
      (commit && last_ff) |=> (state_ff == ST_CLEAR && prefix_ff == '0 &&
                               next_code_ff == NC_W'(1)))
   `LZ_ASSERT_MSG(a_code_bound, clock, reset,
      CMP_W'(next_code_ff) <= CMP_W'(DICT_SIZE), "lz78c next code out of range")

endmodule

@@ hw/rtl/lz78_compressor.sv @@
// Top level of the LZ78 compressor: register port, sequencer, hash unit, table.
// Uses lz78c_pkg, lz78c_seq, lz78c_hash and lz78c_ram.
//
// channel | dir  | handshake               | payload
// req     | in   | req_valid / req_ready   | req_in_byte, req_end_of_stream
// rsp     | out  | rsp_valid / rsp_ready   | prefix_code, out_byte, is_flush,
//         |      |                         | stream_last, dict_full
// csr     | in   | psel, penable, pready   | paddr, pwdata, prdata (dict_limit)
//
// An item is accepted in the idle state, then runs one or more table probes (one
// table read and one compare per probe) until its phrase is resolved.
// After reset and after each end_of_stream item the table is cleared slot by slot,
// during which req_ready is low.
// A result waiting on rsp_ready stalls only an item that must emit one.
module lz78_compressor import lz78c_pkg::*; #(
   parameter int DICT_SIZE  = 4096,
   parameter int HASH_SLOTS = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_in_byte,
   input  logic                  req_end_of_stream,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PREFIX_W-1:0]   rsp_prefix_code,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic                  rsp_is_flush,
   output logic                  rsp_stream_last,
   output logic                  rsp_dict_full,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CODE_W  = $clog2(DICT_SIZE);
   localparam int SLOT_W  = $clog2(HASH_SLOTS);
   localparam int KEY_W   = CODE_W + BYTE_W;
   localparam int ENTRY_W = 1 + KEY_W + CODE_W;

   logic [LIMIT_W-1:0] dict_limit_ff;
   logic [LIMIT_W-1:0] dict_limit_in;
   logic               csr_reg_sel;
   rsp_type            rsp_data;
   hash_cmd_type       hash_cmd;
   logic [KEY_W-1:0]   hash_key;
   logic [SLOT_W-1:0]  hash_idx;
   logic               ram_wr_en;
   logic [SLOT_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [SLOT_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   assign csr_reg_sel = csr_paddr[CSR_ADDR_W-1] == REG_DICT_LIMIT;
   assign csr_pready  = 1'b1;

   always_comb begin
      dict_limit_in = dict_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_reg_sel) begin
         dict_limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dict_limit_ff <= LIMIT_RESET;
      end else begin
         dict_limit_ff <= dict_limit_in;
      end
   end

   assign csr_prdata = csr_reg_sel ? CSR_DATA_W'(dict_limit_ff) : '0;

   lz78c_seq #(
      .DICT_SIZE  (DICT_SIZE),
      .HASH_SLOTS (HASH_SLOTS),
      .CODE_W     (CODE_W),
      .SLOT_W     (SLOT_W),
      .KEY_W      (KEY_W),
      .ENTRY_W    (ENTRY_W)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .dict_limit        (dict_limit_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .hash_cmd          (hash_cmd),
      .hash_key          (hash_key),
      .hash_idx          (hash_idx),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data)
   );

   lz78c_hash #(
      .KEY_W  (KEY_W),
      .SLOT_W (SLOT_W)
   ) u_hash (
      .clock (clock),
      .cmd   (hash_cmd),
      .key   (hash_key),
      .idx   (hash_idx)
   );

   lz78c_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HASH_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_prefix_code = rsp_data.prefix_code;
   assign rsp_out_byte    = rsp_data.out_byte;
   assign rsp_is_flush    = rsp_data.is_flush;
   assign rsp_stream_last = rsp_data.stream_last;
   assign rsp_dict_full   = rsp_data.dict_full;

endmodule
